// ----- src/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// sss_pkg: shared definitions for the sample set statistics block
// Widths, controller state type and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package sss_pkg;

	// sample set geometry
	localparam int SAMPLE_W    = 16;
	localparam int MAX_SAMPLES = 16;
	localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
	localparam int FRAC_W      = 8;

	// accumulator widths
	localparam int SUM_W   = SAMPLE_W + COUNT_W;
	localparam int ABS_W   = SUM_W - 1;
	localparam int SUMSQ_W = 2 * SAMPLE_W + COUNT_W - 2;
	localparam int PROD_W  = COUNT_W + SUMSQ_W;

	// result widths
	localparam int MEAN_W = 24;
	localparam int VAR_W  = 39;
	localparam int STD_W  = 24;

	// divider: dividend is the scaled variance numerator (or scaled |sum| for the mean), divisor is n*n (or n)
	localparam int DIV_W  = VAR_W + FRAC_W;
	localparam int DVR_W  = 2 * COUNT_W - 1;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	// square root: radicand is the variance scaled by another 8 fraction bits
	localparam int ROOT_W = STD_W;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int SREM_W = ROOT_W + 2;
	localparam int SCNT_W = $clog2(ROOT_W + 1);

	// controller states
	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_PROD,
		ST_NUM,
		ST_MEAN,
		ST_VAR,
		ST_ROOT,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic in_open;
		logic ld_prod;
		logic ld_num;
		logic div_start;
		logic div_sel_var;
		logic ld_mean;
		logic ld_var;
		logic sqrt_start;
		logic ld_std;
		logic ld_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_acc;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} sts_t;

endpackage

// ----- src/sss_sample_if.sv -----
// ----------------------------------------------------------------------------
// sss_sample_if: sample channel
// Valid/ready channel carrying one signed sample and its end-of-set flag.
// ----------------------------------------------------------------------------
interface sss_sample_if;
	import sss_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);

endinterface

// ----- src/sss_stats_if.sv -----
// ----------------------------------------------------------------------------
// sss_stats_if: statistics channel
// Valid/ready channel carrying the statistics of one completed sample set.
// ----------------------------------------------------------------------------
interface sss_stats_if;
	import sss_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [COUNT_W-1:0]         sample_count;
	logic signed [SAMPLE_W-1:0] minimum;
	logic signed [SAMPLE_W-1:0] maximum;
	logic signed [MEAN_W-1:0]   mean_q8;
	logic [VAR_W-1:0]           variance_q8;
	logic [STD_W-1:0]           std_dev_q8;

	modport source (
		output valid, output sample_count, output minimum, output maximum,
		output mean_q8, output variance_q8, output std_dev_q8, input ready
	);
	modport sink (
		input valid, input sample_count, input minimum, input maximum,
		input mean_q8, input variance_q8, input std_dev_q8, output ready
	);

endinterface

// ----- src/sss_div.sv -----
// ----------------------------------------------------------------------------
// sss_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. Pulses done as the last
// bit is registered; quotient and remainder flag then hold until restart.
// ----------------------------------------------------------------------------
module sss_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sss_pkg::DIV_W-1:0] dividend,
	input  logic [sss_pkg::DVR_W-1:0] divisor,
	output logic [sss_pkg::DIV_W-1:0] quot,
	output logic                      rem_nz,
	output logic                      done
);
	import sss_pkg::*;

	logic [DIV_W-1:0]  qd_q;
	logic [DVR_W-1:0]  rem_q;
	logic [DVR_W-1:0]  dvr_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [DVR_W:0]    trial;
	logic [DVR_W:0]    diff;
	logic              ge;

	// trial subtract of the divisor from the shifted partial remainder
	assign trial = {rem_q, qd_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvr_q};
	assign ge    = trial >= {1'b0, dvr_q};

	// iteration counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DCNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient shifts in from the bottom as the dividend shifts out the top
	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= dividend;
			rem_q <= '0;
			dvr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
			qd_q  <= {qd_q[DIV_W-2:0], ge};
		end
	end

	assign quot   = qd_q;
	assign rem_nz = |rem_q;
	assign done   = done_q;

endmodule

// ----- src/sss_isqrt.sv -----
// ----------------------------------------------------------------------------
// sss_isqrt: iterative integer square root
// Digit-by-digit root, one result bit per cycle, floor of the exact root.
// Pulses done as the last bit is registered.
// ----------------------------------------------------------------------------
module sss_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sss_pkg::RAD_W-1:0]  radicand,
	output logic [sss_pkg::ROOT_W-1:0] root,
	output logic                       done
);
	import sss_pkg::*;

	logic [RAD_W-1:0]    rad_q;
	logic [SREM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [SCNT_W-1:0]   cnt_q;
	logic                done_q;
	logic [SREM_W+1:0]   trial;
	logic [SREM_W+1:0]   sub;
	logic [SREM_W+1:0]   diff;
	logic                ge;

	// bring down two radicand bits and try 4*root + 1
	assign trial = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign sub   = {2'b00, root_q, 2'b01};
	assign diff  = trial - sub;
	assign ge    = trial >= sub;

	// iteration counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= SCNT_W'(ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - SCNT_W'(1);
				if (cnt_q == SCNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// root and remainder update
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? diff[SREM_W-1:0] : trial[SREM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ----- src/sss_dp.sv -----
// ----------------------------------------------------------------------------
// sss_dp: statistics datapath
// Per-sample accumulators, the final products, the shared divider, the
// square root unit and the output register.
// ----------------------------------------------------------------------------
module sss_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  sss_pkg::cmd_t cmd,
	output sss_pkg::sts_t sts,
	sss_sample_if.sink    samples,
	sss_stats_if.source   stats
);
	import sss_pkg::*;

	logic [COUNT_W-1:0]         count_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] max_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SUMSQ_W-1:0]         sumsq_q;

	logic                         accept;
	logic                         has_room;
	logic signed [2*SAMPLE_W-1:0] sq;

	logic [SUM_W-1:0]     sum_mag;
	logic                 sum_neg;
	logic [PROD_W-1:0]    prod_q;
	logic [2*ABS_W-1:0]   sum2_q;
	logic [PROD_W-1:0]    num_full;
	logic [VAR_W-1:0]     num_q;
	logic [2*COUNT_W-1:0] nsq;

	logic [DIV_W-1:0] div_dividend;
	logic [DVR_W-1:0] div_divisor;
	logic [DIV_W-1:0] div_quot;
	logic             div_rem_nz;
	logic             div_done;
	logic [RAD_W-1:0] radicand;
	logic [ROOT_W-1:0] root;
	logic             sqrt_done;

	logic [MEAN_W:0]          mean_mag;
	logic signed [MEAN_W-1:0] mean_q;
	logic [VAR_W-1:0]         var_q;
	logic [STD_W-1:0]         std_q;
	logic                     out_valid_q;

	// input transaction
	assign samples.ready = cmd.in_open;
	assign accept        = samples.valid && samples.ready;
	assign has_room      = count_q < COUNT_W'(MAX_SAMPLES);
	assign sq            = samples.sample * samples.sample;

	// accumulators, cleared when the report is taken into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= {1'b0, {(SAMPLE_W-1){1'b1}}};
			max_q   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (cmd.ld_out) begin
			count_q <= '0;
			min_q   <= {1'b0, {(SAMPLE_W-1){1'b1}}};
			max_q   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (accept && has_room) begin
			count_q <= count_q + COUNT_W'(1);
			if (samples.sample < min_q) begin
				min_q <= samples.sample;
			end
			if (samples.sample > max_q) begin
				max_q <= samples.sample;
			end
			sum_q   <= sum_q + SUM_W'(samples.sample);
			sumsq_q <= sumsq_q + SUMSQ_W'(sq[2*SAMPLE_W-2:0]);
		end
	end

	// magnitude of the sum and n squared
	assign sum_neg = sum_q[SUM_W-1];
	assign sum_mag = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign nsq     = count_q * count_q;

	// n*sumsq and sum^2, then their difference
	assign num_full = prod_q - PROD_W'(sum2_q);

	always_ff @(posedge clk) begin
		if (cmd.ld_prod) begin
			prod_q <= count_q * sumsq_q;
			sum2_q <= sum_mag[ABS_W-1:0] * sum_mag[ABS_W-1:0];
		end
		if (cmd.ld_num) begin
			num_q <= num_full[VAR_W-1:0];
		end
	end

	// shared divider: scaled |sum| by n, then scaled numerator by n*n
	assign div_dividend = cmd.div_sel_var ? {num_q, FRAC_W'(0)}
	                                      : DIV_W'({sum_mag[ABS_W-1:0], FRAC_W'(0)});
	assign div_divisor  = cmd.div_sel_var ? nsq[DVR_W-1:0] : DVR_W'(count_q);

	sss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quot     (div_quot),
		.rem_nz   (div_rem_nz),
		.done     (div_done)
	);

	// root of the variance with eight more fraction bits
	assign radicand = RAD_W'({div_quot[VAR_W-1:0], FRAC_W'(0)});

	sss_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (radicand),
		.root     (root),
		.done     (sqrt_done)
	);

	// floor of a negative mean rounds the magnitude up on a remainder
	assign mean_mag = {1'b0, div_quot[MEAN_W-1:0]} + (MEAN_W+1)'(div_rem_nz && sum_neg);

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.ld_mean) begin
			mean_q <= sum_neg ? MEAN_W'(-mean_mag) : mean_mag[MEAN_W-1:0];
		end
		if (cmd.ld_var) begin
			var_q <= div_quot[VAR_W-1:0];
		end
		if (cmd.ld_std) begin
			std_q <= root;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			stats.sample_count <= count_q;
			stats.minimum      <= min_q;
			stats.maximum      <= max_q;
			stats.mean_q8      <= mean_q;
			stats.variance_q8  <= var_q;
			stats.std_dev_q8   <= std_q;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (stats.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stats.valid = out_valid_q;

	// status to the controller
	always_comb begin
		sts.last_acc  = accept && samples.last_sample;
		sts.div_done  = div_done;
		sts.sqrt_done = sqrt_done;
		sts.out_free  = !out_valid_q || stats.ready;
	end

endmodule

// ----- src/sss_ctrl.sv -----
// ----------------------------------------------------------------------------
// sss_ctrl: statistics controller
// Sequences accumulation, the final products, the two divisions, the root
// and the hand-over to the output register.
// ----------------------------------------------------------------------------
module sss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  sss_pkg::sts_t sts,
	output sss_pkg::cmd_t cmd
);
	import sss_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (sts.last_acc) begin
					state_nxt = ST_PROD;
				end
			end
			ST_PROD: state_nxt = ST_NUM;
			ST_NUM:  state_nxt = ST_MEAN;
			ST_MEAN: begin
				if (sts.div_done) begin
					state_nxt = ST_VAR;
				end
			end
			ST_VAR: begin
				if (sts.div_done) begin
					state_nxt = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (sts.sqrt_done) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					state_nxt = ST_ACCUM;
				end
			end
			default: state_nxt = ST_ACCUM;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_ACCUM: cmd.in_open = 1'b1;
			ST_PROD:  cmd.ld_prod = 1'b1;
			ST_NUM: begin
				cmd.ld_num    = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_MEAN: begin
				if (sts.div_done) begin
					cmd.ld_mean     = 1'b1;
					cmd.div_start   = 1'b1;
					cmd.div_sel_var = 1'b1;
				end
			end
			ST_VAR: begin
				cmd.div_sel_var = 1'b1;
				if (sts.div_done) begin
					cmd.ld_var     = 1'b1;
					cmd.sqrt_start = 1'b1;
				end
			end
			ST_ROOT: begin
				if (sts.sqrt_done) begin
					cmd.ld_std = 1'b1;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ----- src/sample_set_statistics.sv -----
// ----------------------------------------------------------------------------
// sample_set_statistics: min, max, mean, variance and deviation of a set
// Accumulates signed samples and reports the statistics of each set.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while a set is being gathered; up to 16
// samples are kept and further ones, the flagged last sample among them,
// are dropped. The transaction that carries last_sample closes the set,
// after which the sample channel is held off while the products are formed,
// a shared bit-serial divider makes two passes (for the mean and the
// variance), the bit-serial square root runs and the report is handed over
// to the output register.
// The report then moves into an output register and the next set can start
// at once, while the report waits to be taken; a report only stalls the
// block if the previous one has still not been taken when the next finishes.
// Mean, variance and deviation carry 8 fraction bits and are truncated,
// the mean towards negative infinity.
// ----------------------------------------------------------------------------
module sample_set_statistics (
	input  logic        clk,
	input  logic        arst_n,
	sss_sample_if.sink  samples,
	sss_stats_if.source stats
);
	import sss_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	sss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// accumulation and arithmetic
	sss_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.samples (samples),
		.stats   (stats)
	);

endmodule
